>>> hw/rtl/seeded_word_string_hash_defines.svh
// Assertion macros shared by the seeded word string hash RTL.
// Included by the top level; no other dependencies.
`ifndef SEEDED_WORD_STRING_HASH_DEFINES_SVH
`define SEEDED_WORD_STRING_HASH_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SWSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SWSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/swsh_pkg.sv
// Package for the seeded word string hash: mixer constants, queue depth,
// and the structs passed between front end, back end and mixer. No dependencies.
`default_nettype none

package swsh_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam int unsigned SHIFT_PRE    = 30;
    localparam int unsigned SHIFT_MID    = 27;
    localparam int unsigned SHIFT_FIN    = 31;

    // Default depth of the item queue between front and back end
    localparam int unsigned QUEUE_DEPTH  = 2;

    // Classified item handed from front end to back end
    typedef struct packed {
        logic [63:0] word;      // word with invalid tail bytes cleared
        logic        two_mix;   // full last word: mix word, then zero tail
        logic        last;      // final item of the string
    } t_item;

    // Request from back end to mixer
    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } t_mix_req;

    // Response from mixer to back end
    typedef struct packed {
        logic        ready;
        logic        done;
        logic [63:0] result;
    } t_mix_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/swsh_front.sv
// Front end of the seeded word string hash: accepts items, masks partial
// tail words, flags full last words, and queues them. Uses swsh_pkg.
`default_nettype none

module swsh_front #(
    parameter int unsigned P_QUEUE_DEPTH = swsh_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [63:0]    i_data_word,
    input  wire logic [3:0]     i_valid_bytes,
    input  wire logic           i_last_word,
    output swsh_pkg::t_item     o_item,
    output logic                o_avail,
    input  wire logic           i_take
);
    import swsh_pkg::*;

    localparam int unsigned PTR_W = (P_QUEUE_DEPTH > 1) ? $clog2(P_QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_QUEUE_DEPTH);

    t_item            r_q [P_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;
    logic             full_word;
    logic [63:0]      byte_mask;
    t_item            item_in;

    // Build the byte mask for a partial tail word
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            byte_mask[8*b +: 8] = (i_valid_bytes > 4'(b)) ? 8'hff : 8'h00;
        end
    end

    // Classify: non-last items and counts of eight or more take the whole word
    always_comb begin
        full_word       = !i_last_word || (i_valid_bytes >= 4'd8);
        item_in.word    = full_word ? i_data_word : (i_data_word & byte_mask);
        item_in.two_mix = i_last_word && (i_valid_bytes >= 4'd8);
        item_in.last    = i_last_word;
    end

    assign full    = (r_count == CNT_FULL);
    assign o_avail = (r_count != '0);
    assign o_item  = r_q[r_rd_ptr];
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_avail;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified item
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/swsh_mix.sv
// Finalizer unit of the seeded word string hash: one splitmix64 mix built
// around a single shared 32x32 multiplier. Uses swsh_pkg.
`default_nettype none

module swsh_mix (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire swsh_pkg::t_mix_req i_req,
    output swsh_pkg::t_mix_rsp o_rsp
);
    import swsh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M0   = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_XS   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  r_state, n_state;
    logic        r_ph, n_ph;          // 0: multiply by A, 1: by B
    logic [63:0] r_x, n_x;            // multiplicand
    logic [63:0] r_acc, n_acc;        // product accumulator
    logic [63:0] pre;
    logic [63:0] mul_c;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic        ready;

    assign ready = (r_state == S_IDLE) || (r_state == S_DONE);

    // Select one 32x32 partial product per cycle:
    // low*low, high*low, low*high; the high*high term drops out mod 2^64
    always_comb begin
        mul_c = r_ph ? MIX_MUL_B : MIX_MUL_A;
        op_a  = (r_state == S_M1) ? r_x[63:32] : r_x[31:0];
        op_b  = (r_state == S_M2) ? mul_c[63:32] : mul_c[31:0];
        prod  = 64'(op_a) * 64'(op_b);
        pre   = i_req.value + GOLDEN_GAMMA;
    end

    // Sequence the mix: load, three partials, xor-shift, three partials, done
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_x     = r_x;
        n_acc   = r_acc;
        case (r_state)
            S_IDLE, S_DONE: begin
                if (i_req.start) begin
                    n_x     = pre ^ (pre >> SHIFT_PRE);
                    n_ph    = 1'b0;
                    n_state = S_M0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_M0: begin
                n_acc   = prod;
                n_state = S_M1;
            end
            S_M1: begin
                n_acc   = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
                n_state = S_M2;
            end
            S_M2: begin
                n_acc   = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
                n_state = r_ph ? S_DONE : S_XS;
            end
            S_XS: begin
                n_x     = r_acc ^ (r_acc >> SHIFT_MID);
                n_ph    = 1'b1;
                n_state = S_M0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    // Hold operand and accumulator
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
    end

    assign o_rsp.ready  = ready;
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.result = r_acc ^ (r_acc >> SHIFT_FIN);

endmodule

`default_nettype wire

>>> hw/rtl/swsh_back.sv
// Back end of the seeded word string hash: keeps the running hash, drives
// the mixer per queued item, and holds the result register. Uses swsh_pkg.
`default_nettype none

module swsh_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [63:0]   i_seed,
    input  wire swsh_pkg::t_item i_item,
    input  wire logic          i_avail,
    output logic               o_take,
    output swsh_pkg::t_mix_req o_mix_req,
    input  wire swsh_pkg::t_mix_rsp i_mix_rsp,
    output logic               o_idle,
    output logic               empty,
    input  wire logic          pop,
    output logic [63:0]        o_hash_value
);
    import swsh_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic        r_in_str, n_in_str;
    logic        r_two, n_two;
    logic        r_last, n_last;
    logic [63:0] r_hash, n_hash;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_hash, n_out_hash;
    logic [63:0] start_h;

    assign start_h = r_in_str ? r_hash : (i_seed ^ GOLDEN_GAMMA);

    always_comb begin
        n_state     = r_state;
        n_in_str    = r_in_str;
        n_two       = r_two;
        n_last      = r_last;
        n_hash      = r_hash;
        n_out_hash  = r_out_hash;
        n_out_valid = r_out_valid && !pop;
        o_take          = 1'b0;
        o_mix_req.start = 1'b0;
        o_mix_req.value = i_mix_rsp.result;
        case (r_state)
            // Take the next item and fold it into the running hash
            B_IDLE: begin
                if (i_avail && i_mix_rsp.ready) begin
                    o_take          = 1'b1;
                    o_mix_req.start = 1'b1;
                    o_mix_req.value = start_h ^ i_item.word;
                    n_two           = i_item.two_mix;
                    n_last          = i_item.last;
                    n_state         = B_RUN;
                end
            end
            // Wait for the mix; chain the zero tail after a full last word
            B_RUN: begin
                if (i_mix_rsp.done) begin
                    if (r_two) begin
                        o_mix_req.start = 1'b1;
                        n_two           = 1'b0;
                    end else begin
                        n_hash = i_mix_rsp.result;
                        if (r_last) begin
                            n_state = B_OUT;
                        end else begin
                            n_in_str = 1'b1;
                            n_state  = B_IDLE;
                        end
                    end
                end
            end
            // Hold the final hash until the result register frees up
            B_OUT: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_hash;
                    n_in_str    = 1'b0;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_in_str    <= 1'b0;
            r_two       <= 1'b0;
            r_last      <= 1'b0;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_str    <= n_in_str;
            r_two       <= n_two;
            r_last      <= n_last;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hash <= n_out_hash;
    end

    assign o_idle       = (r_state == B_IDLE);
    assign empty        = !r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

`default_nettype wire

>>> hw/rtl/seeded_word_string_hash.sv
// Top level of the seeded word string hash: seed register, front end queue,
// back end and mixer. Uses swsh_pkg and seeded_word_string_hash_defines.svh.
`default_nettype none

`include "seeded_word_string_hash_defines.svh"

// Hashes a byte string delivered as little-endian 64-bit words, one word per
// push; last_word closes the string and yields one hash on the result queue
// (a last word with fewer than eight valid bytes is masked to its low bytes).
// Each word goes through one splitmix64 finalizer; a last word with a full
// eight bytes gets a second finalizer over a zero tail. The finalizer is
// sequenced over one shared 32x32 multiplier, three partial products per
// 64-bit multiply. A queue of P_QUEUE_DEPTH items in front lets pushes
// continue while the back end works, and a result register holds the
// finished hash until it is popped. The seed is written through the
// configuration channel, always ready, and is sampled at string start.
module seeded_word_string_hash #(
    parameter int unsigned P_QUEUE_DEPTH = swsh_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_valid_bytes,
    input  wire logic        i_last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      o_hash_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_hash_seed
);
    import swsh_pkg::*;

    logic [63:0] r_seed;
    t_item       item;
    logic        avail;
    logic        take;
    logic        back_idle;
    t_mix_req    mix_req;
    t_mix_rsp    mix_rsp;

    // Capture the seed on each configuration write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_hash_seed;
        end
    end

    swsh_front #(
        .P_QUEUE_DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_item        (item),
        .o_avail       (avail),
        .i_take        (take)
    );

    swsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_item       (item),
        .i_avail      (avail),
        .o_take       (take),
        .o_mix_req    (mix_req),
        .i_mix_rsp    (mix_rsp),
        .o_idle       (back_idle),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value)
    );

    swsh_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mix_req),
        .o_rsp   (mix_rsp)
    );

    // Back end never starts the mixer while it is busy
    `SWSH_ASSERT_NOW(a_start_when_ready, i_clk, i_rst_n, mix_req.start, mix_rsp.ready, "mixer started while busy")
    // An idle back end always finds the mixer free
    `SWSH_ASSERT_NOW(a_idle_mix_ready, i_clk, i_rst_n, back_idle, mix_rsp.ready, "mixer busy while back end idle")
    // A waiting item is picked up at once by an idle back end
    `SWSH_ASSERT_NEXT(a_take_queued, i_clk, i_rst_n, avail && back_idle, !back_idle, "queued item not taken")
    // Mix completion lasts a single cycle
    `SWSH_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, mix_rsp.done, !mix_rsp.done, "mix done held")

endmodule

`default_nettype wire
